@@ rtl/core/prewitt_edge_sum_3x3_macros.svh @@
// Assertion macros for the 3x3 edge-sum block checker.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef PREWITT_EDGE_SUM_3X3_MACROS_SVH
`define PREWITT_EDGE_SUM_3X3_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define PES_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pes assertion failed");

// Next-cycle implication, disabled while in reset
`define PES_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pes assertion failed");

`endif

@@ rtl/core/pes_pkg.sv @@
// Shared constants, types and helper functions of the 3x3 edge-sum block.
// No dependencies; used by every module of the block except pes_ram.
`timescale 1ns / 1ps

package pes_pkg;

  // Geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int HEIGHT_MAX = 4096;
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(HEIGHT_MAX);

  // Configuration registers
  localparam int LW_W      = 11;
  localparam int FH_W      = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int LW_RESET  = 512;
  localparam int FH_RESET  = 512;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // Arithmetic widths: column sum, bottom-minus-top, full kernel sum
  localparam int SUM_W  = PIX_W + 2;
  localparam int DIFF_W = PIX_W + 1;
  localparam int ACC_W  = PIX_W + 4;
  localparam int PIX_MAX = (1 << PIX_W) - 1;

  // One window column: upper, middle and lower row pixel
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } pes_col_t;

  // Partial results a column cell hands to the kernel
  typedef struct packed {
    logic [SUM_W-1:0]         col_sum;
    logic signed [DIFF_W-1:0] bt_diff;
  } pes_tap_t;

  // Clamp a line width to 3..MAX_WIDTH and return the last column index
  function automatic logic [COL_W-1:0] last_col(input logic [LW_W-1:0] v);
    logic [COL_W-1:0] r;
    if (int'(v) < 3) begin
      r = COL_W'(2);
    end else if (int'(v) > MAX_WIDTH) begin
      r = COL_W'(MAX_WIDTH - 1);
    end else begin
      r = COL_W'(int'(v) - 1);
    end
    return r;
  endfunction

  // Clamp a frame height to 3..HEIGHT_MAX and return the last row index
  function automatic logic [ROW_W-1:0] last_row(input logic [FH_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (int'(v) < 3) begin
      r = ROW_W'(2);
    end else if (int'(v) > HEIGHT_MAX) begin
      r = ROW_W'(HEIGHT_MAX - 1);
    end else begin
      r = ROW_W'(int'(v) - 1);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/pes_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the line stores.
`timescale 1ns / 1ps

module pes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/pes_cell.sv @@
// Window column cell: holds one 3-pixel column and passes it to its neighbor.
// Depends on pes_pkg for the column and tap types.
`timescale 1ns / 1ps

module pes_cell import pes_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     shift_i,
  input  pes_col_t col_i,
  output pes_col_t col_o,
  output pes_tap_t tap_o
);

  pes_col_t col_q;

  // Load the neighbor's column on each window advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

  // Column sum and lower-minus-upper difference of this column
  always_comb begin
    tap_o.col_sum = SUM_W'(col_q.top) + SUM_W'(col_q.mid) + SUM_W'(col_q.bot);
    tap_o.bt_diff = $signed({1'b0, col_q.bot}) - $signed({1'b0, col_q.top});
  end

endmodule

@@ rtl/core/pes_kernel.sv @@
// Kernel combine: right minus left column plus the three row differences,
// saturated to the pixel range. Depends on pes_pkg.
`timescale 1ns / 1ps

module pes_kernel import pes_pkg::*; (
  input  pes_tap_t         left_i,
  input  pes_tap_t         center_i,
  input  pes_tap_t         right_i,
  output logic [PIX_W-1:0] edge_o
);

  logic signed [ACC_W-1:0] horiz;
  logic signed [ACC_W-1:0] vert;
  logic signed [ACC_W-1:0] total;

  // Sum both gradients
  always_comb begin
    horiz = $signed(ACC_W'(right_i.col_sum)) - $signed(ACC_W'(left_i.col_sum));
    vert  = ACC_W'(left_i.bt_diff) + ACC_W'(center_i.bt_diff) + ACC_W'(right_i.bt_diff);
    total = horiz + vert;
  end

  // Clamp to 0..PIX_MAX
  always_comb begin
    if (total < 0) begin
      edge_o = '0;
    end else if (total > ACC_W'(PIX_MAX)) begin
      edge_o = PIX_W'(PIX_MAX);
    end else begin
      edge_o = total[PIX_W-1:0];
    end
  end

endmodule

@@ rtl/core/prewitt_edge_sum_3x3.sv @@
// 3x3 edge-sum filter: two line stores, a chain of three column cells, kernel.
// Path: an accepted pixel passes stage 1, the window cells (stage 2) and the output register.
// Throughput: one pixel per clock while the output is not stalled; each accept reads both line stores.
// Reset: clears the pipeline, frame counters and window; width and height go
// to 512. Line store contents are not cleared; first two rows give no result.
`timescale 1ns / 1ps

module prewitt_edge_sum_3x3 import pes_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // Pixel input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [PIX_W-1:0]     s_axis_tdata,  // [7:0] pixel
  // Edge output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [PIX_W-1:0]     m_axis_tdata,  // [7:0] edge_value
  output logic                 m_axis_tlast   // frame_end
);

  // Configuration and frame position
  logic [COL_W-1:0] wl_q, wl_d;
  logic [ROW_W-1:0] hl_q, hl_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  // Flow control
  logic accept;
  logic adv;
  logic out_take;
  logic s1_step;

  // Stage 1: pixel waiting for the line store read
  logic             s1_valid_q;
  logic             s1_emit_q;
  logic             s1_last_q;
  logic [PIX_W-1:0] s1_px_q;
  logic [COL_W-1:0] s1_col_q;

  // Stage 2: window complete
  logic s2_valid_q;
  logic s2_last_q;

  // Output register
  logic             m_valid_q;
  logic [PIX_W-1:0] m_data_q;
  logic             m_last_q;

  logic [PIX_W-1:0] up_rd;
  logic [PIX_W-1:0] mid_rd;
  logic [PIX_W-1:0] edge_val;

  pes_col_t new_col;
  pes_col_t col_c2, col_c1, col_c0;
  pes_tap_t tap_c2, tap_c1, tap_c0;

  // Advance unless a finished word is stuck behind a stalled output
  assign out_take      = !m_valid_q || m_axis_tready;
  assign adv           = out_take || !s2_valid_q;
  assign accept        = s_axis_tvalid && adv;
  assign s1_step       = adv && s1_valid_q;
  assign s_axis_tready = adv;

  // Configuration registers
  always_comb begin
    wl_d = wl_q;
    hl_d = hl_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LINE_WIDTH:   wl_d = last_col(cfg_data_i[LW_W-1:0]);
        REG_FRAME_HEIGHT: hl_d = last_row(cfg_data_i[FH_W-1:0]);
        default: ;
      endcase
    end
  end

  // Next frame position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == wl_q) begin
        col_d = '0;
        row_d = (row_q == hl_q) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q  <= last_col(LW_W'(LW_RESET));
      hl_q  <= last_row(FH_W'(FH_RESET));
      col_q <= '0;
      row_q <= '0;
    end else begin
      wl_q  <= wl_d;
      hl_q  <= hl_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  // Stage 1 payload: capture pixel and position flags
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= s_axis_tdata;
      s1_col_q  <= col_q;
      s1_emit_q <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
      s1_last_q <= (row_q == hl_q) && (col_q == wl_q);
    end
  end

  // Line stores: read on accept, rotate rows when stage 1 advances
  pes_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_store_upper (
    .clk_i   (clk_i),
    .we_i    (s1_step),
    .waddr_i (s1_col_q),
    .wdata_i (mid_rd),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (up_rd)
  );

  pes_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_store_middle (
    .clk_i   (clk_i),
    .we_i    (s1_step),
    .waddr_i (s1_col_q),
    .wdata_i (s1_px_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (mid_rd)
  );

  // Window: newest column enters the right cell and moves left
  assign new_col = '{top: up_rd, mid: mid_rd, bot: s1_px_q};

  pes_cell u_cell_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_step),
    .col_i   (new_col),
    .col_o   (col_c2),
    .tap_o   (tap_c2)
  );

  pes_cell u_cell_center (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_step),
    .col_i   (col_c2),
    .col_o   (col_c1),
    .tap_o   (tap_c1)
  );

  pes_cell u_cell_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_step),
    .col_i   (col_c1),
    .col_o   (col_c0),
    .tap_o   (tap_c0)
  );

  pes_kernel u_kernel (
    .left_i   (tap_c0),
    .center_i (tap_c1),
    .right_i  (tap_c2),
    .edge_o   (edge_val)
  );

  // Stage 2: a result is pending while the window holds an interior center
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_step) begin
      s2_last_q <= s1_last_q;
    end
  end

  // Output register: hold the word until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_take) begin
      m_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && s2_valid_q) begin
      m_data_q <= edge_val;
      m_last_q <= s2_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

@@ rtl/core/pes_checker.sv @@
// Port-level checker for the 3x3 edge-sum block, bound to the top level.
// Depends on pes_pkg and prewitt_edge_sum_3x3_macros.svh.
`timescale 1ns / 1ps
`include "prewitt_edge_sum_3x3_macros.svh"

module pes_checker import pes_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [PIX_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  // Stalled output word keeps its valid and contents
  `PES_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // Input backpressure only comes from a stalled output word
  `PES_ASSERT_IMP(a_ready_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // A fresh output word needs a pixel accepted earlier, passed through stage 1, stage 2 and the output register
  `PES_ASSERT_IMP(a_out_source, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 3))

endmodule

bind prewitt_edge_sum_3x3 pes_checker u_pes_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
